[rtl/scs_pkg.sv]
package scs_pkg;

   localparam int ELEM_W = 16;
   localparam int SIM_W  = 16;

   // Finished sums handed from the accumulator to the ratio unit.
   typedef struct packed {
      logic signed [47:0] dot;
      logic [47:0]        qsq;
      logic [47:0]        dsq;
      logic               norm_mode;
   } sums_type;

   localparam int SUMS_W = $bits(sums_type);

endpackage

[rtl/streaming_cosine_similarity.sv]
// channel  ports                                        direction
// req      req_valid/ready, query/doc/last_element      in
// rsp      rsp_valid/ready, similarity, zero_norm       out
// csr      csr_write_enable, csr_write_data             in
// Elements are taken one per cycle into three saturating MACs, except while
// a finished document's sums wait unaccepted. A finished document waits in
// a 2-entry queue for the ratio unit, which runs 16 bit tries, each set by the
// chunked wide multiplies; normalized mode and zero norms skip the bit tries.
// Synchronous active-high reset clears sums, queue and sequencer.
module streaming_cosine_similarity #(
   parameter int MAX_DIMS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_query_element,
   input  logic signed [15:0] req_doc_element,
   input  logic               req_last_element,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_similarity,
   output logic               rsp_zero_norm
);

   logic              mode_ff;
   logic              a_valid, a_ready, f_valid, f_ready;
   scs_pkg::sums_type a_sums, f_sums;
   logic [scs_pkg::SUMS_W-1:0] f_data;

   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_write_enable) mode_ff <= csr_write_data;
   end

   scs_accum #(.MAX_DIMS(MAX_DIMS)) u_acc (
      .clock, .reset, .csr_normalized_mode(mode_ff),
      .in_valid(req_valid), .in_ready(req_ready),
      .in_q(req_query_element), .in_d(req_doc_element), .in_last(req_last_element),
      .out_valid(a_valid), .out_ready(a_ready), .out_sums(a_sums));

   scs_fifo #(.WIDTH(scs_pkg::SUMS_W)) u_q (
      .clock, .reset, .in_valid(a_valid), .in_ready(a_ready), .in_data(a_sums),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data));

   assign f_sums = f_data;

   scs_ratio u_rat (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_sums(f_sums),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_sim(rsp_similarity), .out_zero(rsp_zero_norm));

   a_zero_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_norm |-> rsp_similarity == 16'sd0)
      else $error("zero norm with nonzero similarity");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_similarity))
      else $error("result dropped");

endmodule

[rtl/scs_accum.sv]
module scs_accum #(
   parameter int MAX_DIMS = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_normalized_mode,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [15:0]        in_q,
   input  logic signed [15:0]        in_d,
   input  logic                      in_last,
   output logic                      out_valid,
   input  logic                      out_ready,
   output scs_pkg::sums_type         out_sums
);

   localparam logic signed [49:0] LIM = 50'(MAX_DIMS) <<< 30;

   logic signed [47:0] dot_ff, dot_in;
   logic signed [47:0] qsq_ff, qsq_in;
   logic signed [47:0] dsq_ff, dsq_in;
   logic               out_valid_ff, out_valid_in;
   scs_pkg::sums_type  sums_ff, sums_in;
   logic signed [31:0] p_qd, p_qq, p_dd;
   logic               take;

   function automatic logic signed [47:0] sat(input logic signed [47:0] a,
                                              input logic signed [31:0] b);
      logic signed [49:0] r;
      r = 50'(a) + 50'(b);
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      return r[47:0];
   endfunction

   assign p_qd = in_q * in_d;
   assign p_qq = in_q * in_q;
   assign p_dd = in_d * in_d;
   assign in_ready = !out_valid_ff || out_ready;
   assign take = in_valid && in_ready;

   always_comb begin
      dot_in = dot_ff;
      qsq_in = qsq_ff;
      dsq_in = dsq_ff;
      sums_in = sums_ff;
      out_valid_in = out_valid_ff && !out_ready;
      if (take) begin
         dot_in = sat(dot_ff, p_qd);
         qsq_in = sat(qsq_ff, p_qq);
         dsq_in = sat(dsq_ff, p_dd);
         if (in_last) begin
            sums_in.dot = dot_in;
            sums_in.qsq = qsq_in;
            sums_in.dsq = dsq_in;
            sums_in.norm_mode = csr_normalized_mode;
            out_valid_in = 1'b1;
            dot_in = '0;
            qsq_in = '0;
            dsq_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         qsq_ff <= '0;
         dsq_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         dot_ff <= dot_in;
         qsq_ff <= qsq_in;
         dsq_ff <= dsq_in;
         out_valid_ff <= out_valid_in;
      end
      sums_ff <= sums_in;
   end

   assign out_valid = out_valid_ff;
   assign out_sums = sums_ff;

endmodule

[rtl/scs_fifo.sv]
module scs_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   // two-entry queue
   logic [WIDTH-1:0] mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             wr, rd;

   assign in_ready = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign wr = in_valid && in_ready;
   assign rd = out_valid && out_ready;
   assign out_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr) wp_ff <= !wp_ff;
         if (rd) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
      if (wr) mem_ff[wp_ff] <= in_data;
   end

endmodule

[rtl/scs_ratio.sv]
module scs_ratio (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  scs_pkg::sums_type    in_sums,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [15:0]   out_sim,
   output logic                 out_zero
);

   // Bit search: largest y<=32768 with y^2*qs*ds <= mag^2*2^30.
   // Per bit: y^2 (one mult), *qs (chunks), *ds (chunks), compare.
   typedef enum logic [3:0] {
      IDLE, PREP, MAG2A, MAG2B, TRY, MQ, MD0, MD1, MD2, CMP, DONE
   } state_type;

   state_type          st_ff;
   logic [47:0]        mag_ff;
   logic               neg_ff;
   logic [47:0]        qs_ff, ds_ff;
   logic [127:0]       rhs_ff;
   logic [15:0]        y_ff;
   logic               ytop_ff;
   logic [4:0]         bit_ff;
   logic [31:0]        t2_ff;
   logic [79:0]        tq_ff;
   logic [127:0]       lhs_ff;
   logic               nm_ff;
   logic signed [15:0] sim_ff;
   logic               zero_ff;
   logic               ov_ff;
   logic [16:0]        t;
   logic [47:0]        sdot_mag;

   assign in_ready = (st_ff == IDLE);
   assign out_valid = ov_ff;
   assign out_sim = sim_ff;
   assign out_zero = zero_ff;
   assign sdot_mag = in_sums.dot[47] ? 48'(-in_sums.dot) : in_sums.dot;
   assign t = ({ytop_ff, y_ff} | (17'd1 << bit_ff[3:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= IDLE;
         ov_ff <= 1'b0;
      end else begin
         case (st_ff)
            IDLE: begin
               if (in_valid) begin
                  mag_ff <= sdot_mag;
                  neg_ff <= in_sums.dot[47];
                  qs_ff <= in_sums.qsq;
                  ds_ff <= in_sums.dsq;
                  nm_ff <= in_sums.norm_mode;
                  st_ff <= PREP;
               end
            end
            PREP: begin
               zero_ff <= 1'b0;
               if (nm_ff) begin
                  if (neg_ff) sim_ff <= (mag_ff[47:15] > 33'd32768) ? 16'sh8000
                                        : 16'(-mag_ff[30:15]);
                  else sim_ff <= (mag_ff[47:15] > 33'd32767) ? 16'sh7fff
                                 : 16'(mag_ff[30:15]);
                  st_ff <= DONE;
               end else if (qs_ff == '0 || ds_ff == '0) begin
                  sim_ff <= '0;
                  zero_ff <= 1'b1;
                  st_ff <= DONE;
               end else begin
                  y_ff <= '0;
                  ytop_ff <= 1'b0;
                  bit_ff <= 5'd15;
                  rhs_ff <= 128'(mag_ff[23:0] * mag_ff[23:0]);
                  st_ff <= MAG2A;
               end
            end
            MAG2A: begin
               rhs_ff <= rhs_ff + (128'(mag_ff[47:24] * mag_ff[23:0]) << 25);
               st_ff <= MAG2B;
            end
            MAG2B: begin
               // rhs = mag^2 * 2^30
               rhs_ff <= (rhs_ff + (128'(mag_ff[47:24] * mag_ff[47:24]) << 48)) << 30;
               st_ff <= TRY;
            end
            TRY: begin
               if (t > 17'd32768) begin
                  st_ff <= CMP;
                  lhs_ff <= '1;
               end else begin
                  t2_ff <= 32'(t * t);
                  st_ff <= MQ;
               end
            end
            MQ: begin
               tq_ff <= 80'(t2_ff * qs_ff[23:0]) + (80'(t2_ff * qs_ff[47:24]) << 24);
               st_ff <= MD0;
            end
            MD0: begin
               lhs_ff <= 128'(tq_ff[39:0] * ds_ff[23:0]);
               st_ff <= MD1;
            end
            MD1: begin
               lhs_ff <= lhs_ff + (128'(tq_ff[79:40] * ds_ff[23:0]) << 40)
                         + (128'(tq_ff[39:0] * ds_ff[47:24]) << 24);
               st_ff <= MD2;
            end
            MD2: begin
               lhs_ff <= lhs_ff + (128'(tq_ff[79:40] * ds_ff[47:24]) << 64);
               st_ff <= CMP;
            end
            CMP: begin
               if (lhs_ff <= rhs_ff) {ytop_ff, y_ff} <= t;
               if (bit_ff == 5'd0) begin
                  st_ff <= DONE;
                  if (lhs_ff <= rhs_ff) begin
                     if (neg_ff) sim_ff <= 16'(-t);
                     else sim_ff <= (t > 17'd32767) ? 16'sh7fff : 16'(t);
                  end else begin
                     if (neg_ff) sim_ff <= 16'(-{ytop_ff, y_ff});
                     else sim_ff <= ({ytop_ff, y_ff} > 17'd32767) ? 16'sh7fff
                                    : y_ff;
                  end
               end else begin
                  bit_ff <= bit_ff - 5'd1;
                  st_ff <= TRY;
               end
            end
            DONE: begin
               if (!ov_ff) begin
                  ov_ff <= 1'b1;
               end else if (out_ready) begin
                  ov_ff <= 1'b0;
                  st_ff <= IDLE;
               end
            end
            default: st_ff <= IDLE;
         endcase
      end
   end

endmodule
